// File: sv/cosim_pkg.sv
// Shared types and constants for the cosine similarity block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package cosim_pkg;

    localparam int ELEM_W      = 16;
    localparam int ACC_W       = 48;
    localparam int COUNT_W     = 17;
    localparam int MAX_LENGTH  = 65536;
    localparam int COS_W       = 16;
    localparam int MAG_W       = 15;          // cosine magnitude bits
    localparam int CHUNK_W     = 16;          // multiplier narrow operand
    localparam int WIDE_W      = 128;         // product / compare width
    localparam int P_W         = 96;          // sum_sq_a * sum_sq_b

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PMUL,
        ST_PSAVE,
        ST_RMUL,
        ST_RSAVE,
        ST_KSQ,
        ST_KMUL,
        ST_TEST,
        ST_OUT
    } cosim_state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACC,        // accumulate one element pair
        OP_MUL_P,      // acc += sum_sq_a * sum_sq_b chunk
        OP_SAVE_P,
        OP_MUL_R,      // acc += mag * mag chunk
        OP_SAVE_R,
        OP_KSQ,        // k2 = (2*trial-1)^2
        OP_MUL_K,      // acc += k2 * P chunk
        OP_TEST,
        OP_LOAD
    } cosim_op_t;

    typedef struct packed {
        cosim_op_t  op;
        logic [2:0] chunk;
        logic [3:0] bit_idx;
    } cosim_cmd_t;

endpackage
`default_nettype wire

// File: sv/cosim_ctrl.sv
// Sequencer for the cosine similarity block: handshakes and command issue.
// Depends on cosim_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cosim_ctrl
    import cosim_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       elem_valid,
    output logic            elem_stall,
    input  wire logic       last,
    output logic            result_valid,
    input  wire logic       result_stall,
    output cosim_cmd_t      cmd
);

    cosim_state_t state_reg, state_next;
    logic [2:0]   chunk_reg, chunk_next;
    logic [3:0]   bit_reg, bit_next;
    logic         result_valid_reg, result_valid_next;
    logic         out_busy;

    assign out_busy = result_valid_reg && result_stall;

    always_comb
    begin
        state_next = state_reg;
        chunk_next = chunk_reg;
        bit_next   = bit_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                chunk_next = 3'd0;
                if (elem_valid && last)
                begin
                    state_next = ST_PMUL;
                end
            end
            ST_PMUL:
            begin
                chunk_next = chunk_reg + 3'd1;
                if (chunk_reg == 3'd2)
                begin
                    state_next = ST_PSAVE;
                end
            end
            ST_PSAVE:
            begin
                chunk_next = 3'd0;
                state_next = ST_RMUL;
            end
            ST_RMUL:
            begin
                chunk_next = chunk_reg + 3'd1;
                if (chunk_reg == 3'd2)
                begin
                    state_next = ST_RSAVE;
                end
            end
            ST_RSAVE:
            begin
                bit_next   = 4'(MAG_W - 1);
                state_next = ST_KSQ;
            end
            ST_KSQ:
            begin
                chunk_next = 3'd0;
                state_next = ST_KMUL;
            end
            ST_KMUL:
            begin
                chunk_next = chunk_reg + 3'd1;
                if (chunk_reg == 3'd5)
                begin
                    state_next = ST_TEST;
                end
            end
            ST_TEST:
            begin
                bit_next = bit_reg - 4'd1;
                if (bit_reg == 4'd0)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_KSQ;
                end
            end
            ST_OUT:
            begin
                if (!out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd.op            = OP_NONE;
        cmd.chunk         = chunk_reg;
        cmd.bit_idx       = bit_reg;
        elem_stall        = 1'b1;
        result_valid_next = result_valid_reg && result_stall;
        unique case (state_reg)
            ST_IDLE:
            begin
                elem_stall = 1'b0;
                if (elem_valid)
                begin
                    cmd.op = OP_ACC;
                end
            end
            ST_PMUL:  cmd.op = OP_MUL_P;
            ST_PSAVE: cmd.op = OP_SAVE_P;
            ST_RMUL:  cmd.op = OP_MUL_R;
            ST_RSAVE: cmd.op = OP_SAVE_R;
            ST_KSQ:   cmd.op = OP_KSQ;
            ST_KMUL:  cmd.op = OP_MUL_K;
            ST_TEST:  cmd.op = OP_TEST;
            ST_OUT:
            begin
                if (!out_busy)
                begin
                    cmd.op            = OP_LOAD;
                    result_valid_next = 1'b1;
                end
            end
            default:  cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            chunk_reg        <= 3'd0;
            bit_reg          <= 4'd0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            chunk_reg        <= chunk_next;
            bit_reg          <= bit_next;
            result_valid_reg <= result_valid_next;
        end
    end

    assign result_valid = result_valid_reg;

endmodule
`default_nettype wire

// File: sv/cosim_dp.sv
// Datapath: running sums, shared 48x16 multiplier, cosine bit search, result register.
// Depends on cosim_pkg; driven by cosim_ctrl commands.
`timescale 1ns / 1ps
`default_nettype none
module cosim_dp
    import cosim_pkg::*;
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire cosim_cmd_t                  cmd,
    input  wire logic signed [ELEM_W-1:0]    elem_a,
    input  wire logic signed [ELEM_W-1:0]    elem_b,
    input  wire logic                        last,
    output logic signed [COS_W-1:0]          cosine,
    output logic signed [ACC_W-1:0]          dot_product,
    output logic        [ACC_W-1:0]          sum_sq_a,
    output logic        [ACC_W-1:0]          sum_sq_b,
    output logic                             zero_norm,
    output logic                             overflow
);

    // running state
    logic signed [ACC_W-1:0]   dot_reg;
    logic        [ACC_W-1:0]   sqa_reg, sqb_reg;
    logic        [COUNT_W-1:0] count_reg;
    logic                      ovf_reg;

    // snapshot of the finished vector
    logic signed [ACC_W-1:0]   dot_s_reg;
    logic        [ACC_W-1:0]   sqa_s_reg, sqb_s_reg;
    logic                      ovf_s_reg;

    // search state
    logic [WIDE_W-1:0]         acc_reg, acc_next;
    logic [P_W-1:0]            p_reg;
    logic [P_W-1:0]            r_reg;
    logic [2*CHUNK_W-1:0]      k2_reg;
    logic [MAG_W-1:0]          m_reg;

    // result register
    logic signed [COS_W-1:0]   cos_o_reg;
    logic signed [ACC_W-1:0]   dot_o_reg;
    logic        [ACC_W-1:0]   sqa_o_reg, sqb_o_reg;
    logic                      zn_o_reg, ovf_o_reg;

    // accumulate path
    logic signed [2*ELEM_W-1:0] p_ab, p_aa, p_bb;
    logic signed [ACC_W:0]      dot_sum;
    logic        [ACC_W:0]      sqa_sum, sqb_sum;
    logic signed [ACC_W-1:0]    dot_new;
    logic        [ACC_W-1:0]    sqa_new, sqb_new;
    logic                       dot_sat, sqa_sat, sqb_sat, cnt_full, ovf_new;

    assign p_ab = elem_a * elem_b;
    assign p_aa = elem_a * elem_a;
    assign p_bb = elem_b * elem_b;

    assign dot_sum = {dot_reg[ACC_W-1], dot_reg} + (ACC_W+1)'(p_ab);
    assign sqa_sum = {1'b0, sqa_reg} + {(ACC_W+1-2*ELEM_W)'(0), p_aa};
    assign sqb_sum = {1'b0, sqb_reg} + {(ACC_W+1-2*ELEM_W)'(0), p_bb};

    assign dot_sat = dot_sum[ACC_W] != dot_sum[ACC_W-1];
    assign sqa_sat = sqa_sum[ACC_W];
    assign sqb_sat = sqb_sum[ACC_W];
    assign cnt_full = count_reg >= COUNT_W'(MAX_LENGTH);

    always_comb
    begin
        if (!dot_sat)
        begin
            dot_new = dot_sum[ACC_W-1:0];
        end
        else if (dot_sum[ACC_W])
        begin
            dot_new = {1'b1, {(ACC_W-1){1'b0}}};
        end
        else
        begin
            dot_new = {1'b0, {(ACC_W-1){1'b1}}};
        end
    end

    assign sqa_new = sqa_sat ? {ACC_W{1'b1}} : sqa_sum[ACC_W-1:0];
    assign sqb_new = sqb_sat ? {ACC_W{1'b1}} : sqb_sum[ACC_W-1:0];
    assign ovf_new = ovf_reg | dot_sat | sqa_sat | sqb_sat | cnt_full;

    // magnitude of the finished dot product; -2^47 needs the top bit
    logic [ACC_W-1:0] mag;
    assign mag = dot_s_reg[ACC_W-1] ? ACC_W'(-dot_s_reg) : ACC_W'(dot_s_reg);

    // shared multiplier: 48 x 16, added into the wide accumulator at chunk offset
    logic [ACC_W-1:0]          mul_a;
    logic [CHUNK_W-1:0]        mul_b;
    logic [ACC_W+CHUNK_W-1:0]  pp;
    logic [6:0]                shamt;
    logic [ACC_W-1:0]          sqb_shift, mag_shift;
    logic [P_W-1:0]            p_shift;
    logic [WIDE_W-1:0]         pp_wide;

    assign shamt     = {cmd.chunk, 4'b0000};
    assign sqb_shift = sqb_s_reg >> shamt;
    assign mag_shift = mag >> shamt;
    assign p_shift   = p_reg >> shamt;

    always_comb
    begin
        unique case (cmd.op)
            OP_MUL_P:
            begin
                mul_a = sqa_s_reg;
                mul_b = sqb_shift[CHUNK_W-1:0];
            end
            OP_MUL_R:
            begin
                mul_a = mag;
                mul_b = mag_shift[CHUNK_W-1:0];
            end
            default:
            begin
                mul_a = {(ACC_W-2*CHUNK_W)'(0), k2_reg};
                mul_b = p_shift[CHUNK_W-1:0];
            end
        endcase
    end

    assign pp      = mul_a * mul_b;
    assign pp_wide = {(WIDE_W-ACC_W-CHUNK_W)'(0), pp} << shamt;

    // trial candidate for the current bit; k = 2*trial - 1
    logic [MAG_W-1:0]   trial;
    logic [CHUNK_W-1:0] k_val;
    logic               fits;

    assign trial = m_reg | (MAG_W'(1) << cmd.bit_idx);
    assign k_val = {trial, 1'b0} - CHUNK_W'(1);
    assign fits  = acc_reg <= {r_reg, 32'd0};

    // accumulator starts clean per vector: element transfers, saves and KSQ clear it
    always_comb
    begin
        acc_next = acc_reg;
        unique case (cmd.op)
            OP_MUL_P, OP_MUL_R, OP_MUL_K:         acc_next = acc_reg + pp_wide;
            OP_ACC, OP_SAVE_P, OP_SAVE_R, OP_KSQ: acc_next = '0;
            default:                              acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_reg   <= '0;
            sqa_reg   <= '0;
            sqb_reg   <= '0;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (cmd.op == OP_ACC)
        begin
            if (last)
            begin
                dot_reg   <= '0;
                sqa_reg   <= '0;
                sqb_reg   <= '0;
                count_reg <= '0;
                ovf_reg   <= 1'b0;
            end
            else
            begin
                dot_reg   <= dot_new;
                sqa_reg   <= sqa_new;
                sqb_reg   <= sqb_new;
                count_reg <= cnt_full ? count_reg : count_reg + COUNT_W'(1);
                ovf_reg   <= ovf_new;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_ACC && last)
        begin
            dot_s_reg <= dot_new;
            sqa_s_reg <= sqa_new;
            sqb_s_reg <= sqb_new;
            ovf_s_reg <= ovf_new;
        end
        acc_reg <= acc_next;
        if (cmd.op == OP_SAVE_P)
        begin
            p_reg <= acc_reg[P_W-1:0];
        end
        if (cmd.op == OP_SAVE_R)
        begin
            r_reg <= acc_reg[P_W-1:0];
            m_reg <= '0;
        end
        if (cmd.op == OP_KSQ)
        begin
            k2_reg <= k_val * k_val;
        end
        if (cmd.op == OP_TEST && fits)
        begin
            m_reg <= trial;
        end
        if (cmd.op == OP_LOAD)
        begin
            zn_o_reg  <= (sqa_s_reg == '0) || (sqb_s_reg == '0);
            if ((sqa_s_reg == '0) || (sqb_s_reg == '0))
            begin
                cos_o_reg <= '0;
            end
            else if (dot_s_reg[ACC_W-1])
            begin
                cos_o_reg <= -$signed({1'b0, m_reg});
            end
            else
            begin
                cos_o_reg <= $signed({1'b0, m_reg});
            end
            dot_o_reg <= dot_s_reg;
            sqa_o_reg <= sqa_s_reg;
            sqb_o_reg <= sqb_s_reg;
            ovf_o_reg <= ovf_s_reg;
        end
    end

    assign cosine      = cos_o_reg;
    assign dot_product = dot_o_reg;
    assign sum_sq_a    = sqa_o_reg;
    assign sum_sq_b    = sqb_o_reg;
    assign zero_norm   = zn_o_reg;
    assign overflow    = ovf_o_reg;

endmodule
`default_nettype wire

// File: sv/cosine_similarity.sv
// Top level of the cosine similarity block: sequencer plus datapath.
// Depends on cosim_pkg, cosim_ctrl and cosim_dp.
//
// Streams pairs of signed Q8.8 elements and keeps the dot product and the two
// sums of squares (Q32.16, saturating, overflow flagged). Element pairs are
// taken one per clock while elem_stall is low. The transfer marked last closes
// the vector: the block then holds elem_stall high until the result is loaded
// (longer while the previous result is still held by result_stall), and one
// shared 48x16 multiplier forms sum_sq_a*sum_sq_b and |dot|^2 chunk by chunk
// and then finds the 15-bit cosine magnitude one bit at a time, top bit first,
// by comparing (2m-1)^2*sa*sb against 4*dot^2*2^30. The magnitude is rounded
// to nearest and clamped to 32767; sign follows the dot product. A zero sum of
// squares gives cosine 0 with zero_norm set. The result sits in an output
// register, so the next vector may start while it waits to be taken.
`timescale 1ns / 1ps
`default_nettype none
module cosine_similarity
    import cosim_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     elem_valid,
    output logic                          elem_stall,
    input  wire logic signed [ELEM_W-1:0] elem_a,
    input  wire logic signed [ELEM_W-1:0] elem_b,
    input  wire logic                     last,
    output logic                          result_valid,
    input  wire logic                     result_stall,
    output logic signed [COS_W-1:0]       cosine,
    output logic signed [ACC_W-1:0]       dot_product,
    output logic        [ACC_W-1:0]       sum_sq_a,
    output logic        [ACC_W-1:0]       sum_sq_b,
    output logic                          zero_norm,
    output logic                          overflow
);

    cosim_cmd_t cmd;

    cosim_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .elem_valid   (elem_valid),
        .elem_stall   (elem_stall),
        .last         (last),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .cmd          (cmd)
    );

    cosim_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .elem_a      (elem_a),
        .elem_b      (elem_b),
        .last        (last),
        .cosine      (cosine),
        .dot_product (dot_product),
        .sum_sq_a    (sum_sq_a),
        .sum_sq_b    (sum_sq_b),
        .zero_norm   (zero_norm),
        .overflow    (overflow)
    );

endmodule
`default_nettype wire

// File: sv/cosim_checker.sv
// Port-level checks for cosine_similarity, bound to the top level.
// Depends on cosim_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cosim_checker
    import cosim_pkg::*;
(
    input wire logic                     clk,
    input wire logic                     rst_n,
    input wire logic                     elem_valid,
    input wire logic                     elem_stall,
    input wire logic                     last,
    input wire logic                     result_valid,
    input wire logic                     result_stall,
    input wire logic signed [COS_W-1:0]  cosine,
    input wire logic        [ACC_W-1:0]  sum_sq_a,
    input wire logic                     zero_norm
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(cosine))
        else $error("held result dropped or changed");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        elem_valid && !elem_stall && last |=> elem_stall)
        else $error("input taken during cosine search");

    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && zero_norm |-> cosine == '0)
        else $error("zero norm with non-zero cosine");

    a_norm: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && sum_sq_a == '0 |-> zero_norm)
        else $error("zero sum of squares not flagged");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> cosine != {1'b1, {(COS_W-1){1'b0}}})
        else $error("cosine outside clamp");

endmodule

bind cosine_similarity cosim_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .elem_valid   (elem_valid),
    .elem_stall   (elem_stall),
    .last         (last),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .cosine       (cosine),
    .sum_sq_a     (sum_sq_a),
    .zero_norm    (zero_norm)
);
`default_nettype wire

// File: tb/cosim_checker.sv
// Checker for the cosine similarity block: watches both channels, predicts results.
// Depends on cosim_pkg for the field widths; instantiated by tb_top.
`timescale 1ns / 1ps
module cosim_tb_checker
    import cosim_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     elem_valid,
    input  logic                     elem_stall,
    input  logic signed [ELEM_W-1:0] elem_a,
    input  logic signed [ELEM_W-1:0] elem_b,
    input  logic                     last,
    input  logic                     result_valid,
    input  logic                     result_stall,
    input  logic signed [COS_W-1:0]  cosine,
    input  logic signed [ACC_W-1:0]  dot_product,
    input  logic        [ACC_W-1:0]  sum_sq_a,
    input  logic        [ACC_W-1:0]  sum_sq_b,
    input  logic                     zero_norm,
    input  logic                     overflow,
    output int                       errors,
    output int                       pending
);

    localparam longint DOT_HI = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint DOT_LO = -64'sh0000_8000_0000_0000;
    localparam logic [63:0] SQ_HI = 64'h0000_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic signed [COS_W-1:0] cos_v;
        logic signed [ACC_W-1:0] dot_v;
        logic [ACC_W-1:0]        sqa_v;
        logic [ACC_W-1:0]        sqb_v;
        logic                    zn_v;
        logic                    ovf_v;
    } similarity_t;

    similarity_t similarity_q[$];

    longint      dot_sum;
    logic [63:0] sq_a_sum;
    logic [63:0] sq_b_sum;
    int          pair_count;
    logic        sat_seen;

    // rounded Q0.15 magnitude: largest m with (2m-1)^2*sa*sb <= (|dot|*2^16)^2
    function automatic logic [MAG_W-1:0] cos_mag(logic [63:0] mag, logic [63:0] sa,
                                                 logic [63:0] sb);
        logic [191:0] norm_prod;
        logic [191:0] dot_sq;
        logic [191:0] trial;
        logic [63:0]  shifted;
        logic [63:0]  k;
        int           lo;
        int           hi;
        int           mid;
        norm_prod = {128'd0, sa} * {128'd0, sb};
        shifted   = mag << 16;
        dot_sq    = {128'd0, shifted} * {128'd0, shifted};
        lo = 0;
        hi = 32767;
        while (lo < hi)
        begin
            mid   = (lo + hi + 1) / 2;
            k     = 2 * mid - 1;
            trial = {128'd0, k * k} * norm_prod;
            if (trial <= dot_sq)
                lo = mid;
            else
                hi = mid - 1;
        end
        return lo[MAG_W-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        longint      ea;
        longint      eb;
        longint      d;
        logic [63:0] s;
        logic [63:0] mag;
        similarity_t e;
        similarity_t got;
        if (!rst_n)
        begin
            dot_sum    = 0;
            sq_a_sum   = 0;
            sq_b_sum   = 0;
            pair_count = 0;
            sat_seen   = 0;
            errors     = 0;
            pending    = 0;
            similarity_q.delete();
        end
        else
        begin
            // result side first, so its expectation count stays consistent
            if (result_valid && !result_stall)
            begin
                got = '{cosine, dot_product, sum_sq_a, sum_sq_b, zero_norm, overflow};
                if (similarity_q.size() == 0)
                begin
                    if (errors < 10)
                        $display("%0t: result with nothing expected", $realtime);
                    errors = errors + 1;
                end
                else
                begin
                    e = similarity_q.pop_front();
                    pending = pending - 1;
                    if (got !== e)
                    begin
                        if (errors < 10)
                        begin
                            $display("%0t: mismatch exp cos %0d dot %0d sa %0d sb %0d zn %b ov %b",
                                     $realtime, e.cos_v, e.dot_v, e.sqa_v, e.sqb_v,
                                     e.zn_v, e.ovf_v);
                            $display("    got cos %0d dot %0d sa %0d sb %0d zn %b ov %b",
                                     got.cos_v, got.dot_v, got.sqa_v, got.sqb_v,
                                     got.zn_v, got.ovf_v);
                        end
                        errors = errors + 1;
                    end
                end
            end
            if (elem_valid && !elem_stall)
            begin
                ea = elem_a;
                eb = elem_b;
                d  = dot_sum + ea * eb;
                if (d > DOT_HI)
                begin
                    d = DOT_HI;
                    sat_seen = 1;
                end
                if (d < DOT_LO)
                begin
                    d = DOT_LO;
                    sat_seen = 1;
                end
                dot_sum = d;
                s = sq_a_sum + 64'(ea * ea);
                if (s > SQ_HI)
                begin
                    s = SQ_HI;
                    sat_seen = 1;
                end
                sq_a_sum = s;
                s = sq_b_sum + 64'(eb * eb);
                if (s > SQ_HI)
                begin
                    s = SQ_HI;
                    sat_seen = 1;
                end
                sq_b_sum = s;
                if (pair_count >= MAX_LENGTH)
                    sat_seen = 1;
                else
                    pair_count = pair_count + 1;
                if (last)
                begin
                    e.zn_v  = (sq_a_sum == 0) || (sq_b_sum == 0);
                    e.cos_v = 0;
                    if (!e.zn_v)
                    begin
                        mag     = (dot_sum < 0) ? 64'(-dot_sum) : 64'(dot_sum);
                        e.cos_v = {1'b0, cos_mag(mag, sq_a_sum, sq_b_sum)};
                        if (dot_sum < 0)
                            e.cos_v = -e.cos_v;
                    end
                    e.dot_v = dot_sum[ACC_W-1:0];
                    e.sqa_v = sq_a_sum[ACC_W-1:0];
                    e.sqb_v = sq_b_sum[ACC_W-1:0];
                    e.ovf_v = sat_seen;
                    similarity_q.push_back(e);
                    pending    = pending + 1;
                    dot_sum    = 0;
                    sq_a_sum   = 0;
                    sq_b_sum   = 0;
                    pair_count = 0;
                    sat_seen   = 0;
                end
            end
        end
    end

endmodule

// File: tb/tb_top.sv
// Testbench top for cosine_similarity: clock, reset, stimulus and verdict.
// Depends on cosim_pkg, the block itself and cosim_tb_checker.
`timescale 1ns / 1ps
module tb_top;
    import cosim_pkg::*;

    logic                     clk = 0;
    logic                     rst_n = 0;
    logic                     elem_valid = 0;
    logic                     elem_stall;
    logic signed [ELEM_W-1:0] elem_a = 0;
    logic signed [ELEM_W-1:0] elem_b = 0;
    logic                     last = 0;
    logic                     result_valid;
    logic                     result_stall = 0;
    logic signed [COS_W-1:0]  cosine;
    logic signed [ACC_W-1:0]  dot_product;
    logic        [ACC_W-1:0]  sum_sq_a;
    logic        [ACC_W-1:0]  sum_sq_b;
    logic                     zero_norm;
    logic                     overflow;
    int                       errors;
    int                       pending;

    // idling odds in percent, changed per phase
    int send_gap_pct  = 0;
    int recv_hold_pct = 0;

    always
    begin
        #1 clk = 1;
        #1 clk = 0;
    end

    cosine_similarity u_dut (
        .clk(clk), .rst_n(rst_n),
        .elem_valid(elem_valid), .elem_stall(elem_stall),
        .elem_a(elem_a), .elem_b(elem_b), .last(last),
        .result_valid(result_valid), .result_stall(result_stall),
        .cosine(cosine), .dot_product(dot_product),
        .sum_sq_a(sum_sq_a), .sum_sq_b(sum_sq_b),
        .zero_norm(zero_norm), .overflow(overflow)
    );

    cosim_tb_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .elem_valid(elem_valid), .elem_stall(elem_stall),
        .elem_a(elem_a), .elem_b(elem_b), .last(last),
        .result_valid(result_valid), .result_stall(result_stall),
        .cosine(cosine), .dot_product(dot_product),
        .sum_sq_a(sum_sq_a), .sum_sq_b(sum_sq_b),
        .zero_norm(zero_norm), .overflow(overflow),
        .errors(errors), .pending(pending)
    );

    // receiver back-pressure, random per cycle
    always @(posedge clk)
        result_stall <= ($urandom_range(99) < recv_hold_pct);

    // One element pair per transfer. Called at a rising edge; returns at the edge
    // where the transfer happened, leaving valid high for the next one.
    task automatic send_pair(input logic [15:0] a, input logic [15:0] b, input logic l);
        while ($urandom_range(99) < send_gap_pct)
        begin
            elem_valid <= 0;
            @(posedge clk);
        end
        elem_valid <= 1;
        elem_a     <= a;
        elem_b     <= b;
        last       <= l;
        // stall is settled by the falling edge
        do
            @(negedge clk);
        while (elem_stall);
        @(posedge clk);
    endtask

    // sender holds off until every outstanding result has been taken
    task automatic drain;
        elem_valid <= 0;
        do
            @(negedge clk);
        while (pending != 0);
        @(posedge clk);
    endtask

    function automatic logic [15:0] pick_elem;
        case ($urandom_range(5))
            0: pick_elem = 16'h0000;
            1: pick_elem = $urandom_range(1) ? 16'h7FFF : 16'h8000;
            2: pick_elem = 16'($signed($urandom_range(1024)) - 512);
            default: pick_elem = 16'($urandom);
        endcase
    endfunction

    // vector of random content; now and then b is all zero, a copy or a negation
    // of a; for non-zero a, a copy or (no 8000h) a negation clamps the cosine
    task automatic send_vector(input int len);
        logic [15:0] a;
        logic [15:0] b;
        int          shape;
        shape = $urandom_range(5);
        for (int i = 0; i < len; i++)
        begin
            a = pick_elem();
            case (shape)
                0: b = a;
                1: b = -a;
                2: b = 16'h0000;
                default: b = pick_elem();
            endcase
            send_pair(a, b, i == len - 1);
        end
    endtask

    initial
    begin
        int phase_gap[4];
        int phase_hold[4];
        phase_gap  = '{0, 50, 0, 32};
        phase_hold = '{0, 0, 50, 32};

        repeat (7) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: extremes, zero norms, parallel, antiparallel, orthogonal
        send_pair(16'h7FFF, 16'h7FFF, 1);
        send_pair(16'h8000, 16'h8000, 1);
        send_pair(16'h8000, 16'h7FFF, 1);
        send_pair(16'h7FFF, 16'h8000, 1);
        send_pair(16'h0000, 16'h0123, 0);
        send_pair(16'h0000, 16'hFF00, 1);
        send_pair(16'h0100, 16'h0000, 1);
        send_pair(16'h0000, 16'h0000, 1);
        send_pair(16'h0100, 16'h0000, 0);
        send_pair(16'h0000, 16'h0100, 1);
        send_pair(16'h0300, 16'h0300, 0);
        send_pair(16'hFD00, 16'hFD00, 1);
        send_pair(16'h0180, 16'hFE80, 0);
        send_pair(16'h0040, 16'hFFC0, 1);
        send_pair(16'h0001, 16'h0002, 0);
        send_pair(16'h0001, 16'h0001, 1);
        send_pair(16'h5555, 16'hAAAA, 1);
        drain();

        for (int p = 0; p < 4; p++)
        begin
            send_gap_pct  = phase_gap[p];
            recv_hold_pct = phase_hold[p];
            for (int n = 0; n < 200; )
            begin
                int len;
                len = ($urandom_range(9) == 0) ? $urandom_range(40, 1)
                                               : $urandom_range(6, 1);
                send_vector(len);
                n += len;
            end
            drain();
        end

        elem_valid <= 0;
        do
            @(negedge clk);
        while (pending != 0);
        repeat (300) @(posedge clk);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // safety net well beyond the slowest legal run
    initial
    begin
        #4000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
